### rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by deq_front, deq_back and double_ended_queue; depends on nothing.
package deq_pkg;

   // Command codes on req_cmd
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_DUMP       = 3'd4;

   // Status codes on rsp_status
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_DUMP,
      OP_NONE
   } op_type;

   // Head of the command queue as seen by the back part
   typedef struct packed {
      logic   valid;
      op_type op;
   } cmd_type;

   // Back part sequencer
   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

endpackage

### rtl/double_ended_queue.sv
// Top level of the double-ended queue: front classifier and command queue,
// back executor with the ring store. Depends on deq_pkg, deq_front, deq_back.
//
//   channel   ports                                          flow control
//   command   start, busy, req_cmd, req_value               start & !busy
//   result    rsp_strobe, rsp_value_out, rsp_status,        strobe only
//             rsp_occupancy, rsp_last
//
// Push, pop and unused codes give one result beat each; a dump gives one beat
// per stored word (one when empty) through the single ring port and takes no
// new command until its last beat. An accepted command goes through the command
// queue to the idle back end and its first beat through the result registers.
// busy rises only when the two-entry command queue is full.
// Reset is synchronous and empties the queue; no clearing pass is needed.
// The receiver cannot stall: every result is shown for exactly one cycle.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_value_out,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_occupancy,
   output logic               rsp_last
);

   cmd_type          cmd_head;
   logic [WIDTH-1:0] cmd_word;
   logic             cmd_pop;

   deq_front #(
      .WIDTH (WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_cmd   (req_cmd),
      .req_value (req_value),
      .cmd_head  (cmd_head),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop)
   );

   deq_back #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_head      (cmd_head),
      .cmd_word      (cmd_word),
      .cmd_pop       (cmd_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

endmodule

### rtl/deq_front.sv
// Front part: accepts command beats, classifies them and holds them in a
// two-entry command queue. Depends on deq_pkg.
module deq_front import deq_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_cmd,
   input  logic signed [31:0]  req_value,
   output cmd_type             cmd_head,
   output logic [WIDTH-1:0]    cmd_word,
   input  logic                cmd_pop
);

   logic [31:0]      value_bits;
   op_type           op_class;
   logic             push;
   op_type           op_q [2];
   logic [WIDTH-1:0] word_q [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   // Classify the incoming command
   always_comb begin
      case (req_cmd)
         CMD_PUSH_FRONT: op_class = OP_PUSH_FRONT;
         CMD_PUSH_BACK:  op_class = OP_PUSH_BACK;
         CMD_POP_FRONT:  op_class = OP_POP_FRONT;
         CMD_POP_BACK:   op_class = OP_POP_BACK;
         CMD_DUMP:       op_class = OP_DUMP;
         default:        op_class = OP_NONE;
      endcase
   end

   assign value_bits = req_value;
   assign busy       = (fill_ff == 2'd2);
   assign push       = start && !busy;

   // Advance queue pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold the accepted beat in the queue
   always_ff @(posedge clock) begin
      if (push) begin
         op_q[wr_ptr_ff]   <= op_class;
         word_q[wr_ptr_ff] <= WIDTH'(value_bits);
      end
   end

   assign cmd_head.valid = (fill_ff != 2'd0);
   assign cmd_head.op    = op_q[rd_ptr_ff];
   assign cmd_word       = word_q[rd_ptr_ff];

endmodule

### rtl/deq_back.sv
// Back part: runs queued commands against the ring store and drives the
// result beats. Depends on deq_pkg.
module deq_back import deq_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd_head,
   input  logic [WIDTH-1:0]   cmd_word,
   output logic               cmd_pop,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_value_out,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_occupancy,
   output logic               rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] ring_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   state_type        state_ff, state_in;
   logic [AW-1:0]    front_ff, front_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;

   logic             res_strobe_ff, res_strobe_in;
   logic             res_mem_ff, res_mem_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [CW-1:0]    res_occ_ff, res_occ_in;
   logic             res_last_ff, res_last_in;

   logic             is_full;
   logic             is_empty;
   logic             dump_last;

   // Ring position of the word at a given offset from the front
   function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
      return AW'(sum);
   endfunction

   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign dump_last = (idx_ff == count_ff - CW'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_head.valid && cmd_head.op == OP_DUMP && count_ff > CW'(1))
               state_in = ST_DUMP;
         end
         ST_DUMP: begin
            if (dump_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and result setup
   always_comb begin
      cmd_pop       = 1'b0;
      front_in      = front_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      res_strobe_in = 1'b0;
      res_mem_in    = 1'b0;
      res_status_in = STATUS_OK;
      res_occ_in    = count_ff;
      res_last_in   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_head.valid) begin
               cmd_pop       = 1'b1;
               res_strobe_in = 1'b1;
               case (cmd_head.op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (is_full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (cmd_head.op == OP_PUSH_FRONT) begin
                           front_in = (front_ff == '0) ? AW'(DEPTH - 1)
                                                       : front_ff - AW'(1);
                           wr_addr  = front_in;
                        end else begin
                           wr_addr = ring_pos(front_ff, count_ff);
                        end
                        res_occ_in = count_in;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (is_empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en      = 1'b1;
                        res_mem_in = 1'b1;
                        count_in   = count_ff - CW'(1);
                        if (cmd_head.op == OP_POP_FRONT) begin
                           rd_addr  = front_ff;
                           front_in = ring_pos(front_ff, CW'(1));
                        end else begin
                           rd_addr = ring_pos(front_ff, count_in);
                        end
                        // Drop back to the origin once the queue drains
                        if (count_in == '0) front_in = '0;
                        res_occ_in = count_in;
                     end
                  end
                  OP_DUMP: begin
                     if (is_empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en       = 1'b1;
                        res_mem_in  = 1'b1;
                        rd_addr     = front_ff;
                        idx_in      = CW'(1);
                        res_last_in = (count_ff == CW'(1));
                     end
                  end
                  default: begin
                     res_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            // Stream one stored word per cycle, front to back
            rd_en         = 1'b1;
            rd_addr       = ring_pos(front_ff, idx_ff);
            res_strobe_in = 1'b1;
            res_mem_in    = 1'b1;
            res_last_in   = dump_last;
            idx_in        = idx_ff + CW'(1);
         end
         default: begin
            res_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         res_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         res_strobe_ff <= res_strobe_in;
      end
   end

   // Result side info, no reset needed
   always_ff @(posedge clock) begin
      res_mem_ff    <= res_mem_in;
      res_status_ff <= res_status_in;
      res_occ_ff    <= res_occ_in;
      res_last_ff   <= res_last_in;
   end

   // Ring store: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) ring_mem[wr_addr] <= cmd_word;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= ring_mem[rd_addr];
   end

   assign rsp_strobe    = res_strobe_ff;
   assign rsp_value_out = res_mem_ff ? signed'(32'(rd_data_ff)) : '0;
   assign rsp_status    = res_status_ff;
   assign rsp_occupancy = 5'(res_occ_ff);
   assign rsp_last      = res_last_ff;

endmodule
